@@ hw/rtl/tsm_pkg.sv @@
// Package for the tolerant sequence match block: item mode codes, the tolerance width
// and the per-beat command struct. It has no dependencies.
`timescale 1ns / 1ps

package tsm_pkg;

    localparam int TOL_BITS = 8;

    localparam logic [1:0] MODE_APPEND  = 2'd0;
    localparam logic [1:0] MODE_POOL    = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    // Decoded form of one beat as it leaves the input register.
    typedef struct packed {
        logic fire;
        logic append;
        logic pool;
        logic restart;
    } tsm_cmd_t;

endpackage

@@ hw/rtl/tolerant_sequence_match.sv @@
// Top level of the tolerant sequence match block: input register, handshake and result
// register around tsm_engine. Depends on tsm_pkg and tsm_engine.
`timescale 1ns / 1ps

// Tolerant sequence match. Beats with mode 0 append pattern elements (up to MAX_PATTERN),
// beats with mode 1 stream pool values, and mode 2 restarts the search and clears the
// pattern; mode 3 changes nothing. Every beat yields exactly one result beat. A pool value
// matches an element when their difference is at most the tolerance register, and a result
// with match set gives the pool position where that whole-pattern match began, together
// with a saturating match count. Appends to a full pattern and pool values at the last
// position are ignored and flagged with overflow. The block takes one beat every cycle while
// the result side is not stalled: all element comparisons run in parallel and the shift-and
// update of the partial-match vector is a single step, and each result passes through the
// input register, then the result register. The input stalls only while a stalled result
// has a second beat waiting behind it. Write the tolerance only while idle.
module tolerant_sequence_match
    import tsm_pkg::*;
#(
    parameter int MAX_PATTERN = 32,
    parameter int VALUE_BITS  = 12,
    parameter int INDEX_BITS  = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tolerance_wr_en,
    input  logic [TOL_BITS-1:0]   tolerance_wr_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            mode,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  match,
    output logic [INDEX_BITS-1:0] start_index,
    output logic [INDEX_BITS-1:0] match_total,
    output logic                  overflow
);

    logic                  s1_valid_reg;
    logic [1:0]            s1_mode_reg;
    logic [VALUE_BITS-1:0] s1_value_reg;

    logic                  out_valid_reg;
    logic                  match_reg;
    logic [INDEX_BITS-1:0] start_reg;
    logic [INDEX_BITS-1:0] total_reg;
    logic                  overflow_reg;

    logic                  out_free;
    logic                  accept;
    tsm_cmd_t              cmd;
    logic                  eng_match;
    logic [INDEX_BITS-1:0] eng_start;
    logic [INDEX_BITS-1:0] eng_total;
    logic                  eng_overflow;

    // The result register can take a new beat when it is empty or being drained.
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        cmd         = '0;
        cmd.fire    = s1_valid_reg && out_free;
        case (s1_mode_reg)
            MODE_APPEND:  cmd.append  = 1'b1;
            MODE_POOL:    cmd.pool    = 1'b1;
            MODE_RESTART: cmd.restart = 1'b1;
            default:      cmd.append  = 1'b0;
        endcase
    end

    tsm_engine #(
        .MAX_PATTERN (MAX_PATTERN),
        .VALUE_BITS  (VALUE_BITS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_engine (
        .clk               (clk),
        .rst_n             (rst_n),
        .tolerance_wr_en   (tolerance_wr_en),
        .tolerance_wr_data (tolerance_wr_data),
        .cmd               (cmd),
        .value             (s1_value_reg),
        .match             (eng_match),
        .start_index       (eng_start),
        .match_total       (eng_total),
        .overflow          (eng_overflow)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg  <= mode;
            s1_value_reg <= value;
        end
        if (cmd.fire)
        begin
            match_reg    <= eng_match;
            start_reg    <= eng_start;
            total_reg    <= eng_total;
            overflow_reg <= eng_overflow;
        end
    end

    assign out_valid   = out_valid_reg;
    assign match       = match_reg;
    assign start_index = start_reg;
    assign match_total = total_reg;
    assign overflow    = overflow_reg;

    // A held beat in the input register must move on whenever the result side is free.
    a_no_lost_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_free) |=> out_valid_reg)
        else $error("beat dropped between input and result registers");

    // The input side stalls only while a beat is waiting in the input register.
    a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a waiting beat");

    // A stalled result must not be overwritten by the beat behind it.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !cmd.fire)
        else $error("result register loaded while stalled");

endmodule

@@ hw/rtl/tsm_lanes.sv @@
// Pattern store and one tolerance comparator per pattern element.
// Depends on tsm_pkg for the tolerance width.
`timescale 1ns / 1ps

module tsm_lanes
    import tsm_pkg::*;
#(
    parameter int MAX_PATTERN = 32,
    parameter int VALUE_BITS  = 12,
    parameter int LEN_W       = 6
)
(
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [LEN_W-1:0]       length,
    input  logic [VALUE_BITS-1:0]  value,
    input  logic [TOL_BITS-1:0]    tolerance,
    output logic [MAX_PATTERN-1:0] hit,
    output logic [MAX_PATTERN-1:0] last
);

    localparam int CMP_W = (VALUE_BITS > TOL_BITS) ? VALUE_BITS : TOL_BITS;

    logic [CMP_W-1:0] tol_ext;

    assign tol_ext = CMP_W'(tolerance);

    for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_lane
        logic [VALUE_BITS-1:0] elem_reg;
        logic [VALUE_BITS-1:0] diff;

        // An element is written when it is appended at the current length.
        always_ff @(posedge clk)
        begin
            if (wr_en && (length == LEN_W'(i)))
            begin
                elem_reg <= value;
            end
        end

        assign diff = (value > elem_reg) ? (value - elem_reg) : (elem_reg - value);

        // Lanes at or beyond the length hold stale data and never report a hit.
        assign hit[i]  = (length > LEN_W'(i)) && (CMP_W'(diff) <= tol_ext);
        assign last[i] = (length == LEN_W'(i + 1));
    end

endmodule

@@ hw/rtl/tsm_engine.sv @@
// Search state (tolerance, pattern length, partial-match bits, pool position, match
// count) and the single-step shift-and update. Depends on tsm_pkg and tsm_lanes.
`timescale 1ns / 1ps

module tsm_engine
    import tsm_pkg::*;
#(
    parameter int MAX_PATTERN = 32,
    parameter int VALUE_BITS  = 12,
    parameter int INDEX_BITS  = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tolerance_wr_en,
    input  logic [TOL_BITS-1:0]   tolerance_wr_data,
    input  tsm_cmd_t              cmd,
    input  logic [VALUE_BITS-1:0] value,
    output logic                  match,
    output logic [INDEX_BITS-1:0] start_index,
    output logic [INDEX_BITS-1:0] match_total,
    output logic                  overflow
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    logic [TOL_BITS-1:0]    tol_reg;
    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W-1:0]       len_next;
    logic [MAX_PATTERN-1:0] partial_reg;
    logic [MAX_PATTERN-1:0] partial_next;
    logic [INDEX_BITS-1:0]  pos_reg;
    logic [INDEX_BITS-1:0]  pos_next;
    logic [INDEX_BITS-1:0]  found_reg;
    logic [INDEX_BITS-1:0]  found_next;

    logic                   full;
    logic                   pos_limit;
    logic                   store_wr;
    logic [MAX_PATTERN-1:0] hit;
    logic [MAX_PATTERN-1:0] last;
    logic [MAX_PATTERN-1:0] partial_shift;
    logic                   full_match;
    logic                   pool_ok;

    assign full      = (len_reg == LEN_W'(MAX_PATTERN));
    assign pos_limit = &pos_reg;
    assign store_wr  = cmd.fire && cmd.append && !full;
    assign pool_ok   = cmd.pool && !pos_limit;

    tsm_lanes #(
        .MAX_PATTERN (MAX_PATTERN),
        .VALUE_BITS  (VALUE_BITS),
        .LEN_W       (LEN_W)
    ) u_lanes (
        .clk       (clk),
        .wr_en     (store_wr),
        .length    (len_reg),
        .value     (value),
        .tolerance (tol_reg),
        .hit       (hit),
        .last      (last)
    );

    // Bit i of the partial vector means elements 0 to i match ending at this value.
    assign partial_shift = ((partial_reg << 1) | MAX_PATTERN'(1)) & hit;
    assign full_match    = |(partial_shift & last);

    always_comb
    begin
        len_next     = len_reg;
        partial_next = partial_reg;
        pos_next     = pos_reg;
        found_next   = found_reg;
        match        = 1'b0;
        start_index  = '0;
        overflow     = 1'b0;
        if (cmd.append)
        begin
            if (full)
            begin
                overflow = 1'b1;
            end
            else
            begin
                len_next = len_reg + LEN_W'(1);
            end
        end
        else if (cmd.pool)
        begin
            if (pos_limit)
            begin
                overflow = 1'b1;
            end
            else
            begin
                partial_next = partial_shift;
                pos_next     = pos_reg + INDEX_BITS'(1);
                if (full_match)
                begin
                    match       = 1'b1;
                    start_index = pos_reg - INDEX_BITS'(len_reg) + INDEX_BITS'(1);
                    if (!(&found_reg))
                    begin
                        found_next = found_reg + INDEX_BITS'(1);
                    end
                end
            end
        end
        else if (cmd.restart)
        begin
            len_next     = '0;
            partial_next = '0;
            pos_next     = '0;
            found_next   = '0;
        end
        match_total = found_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg     <= '0;
            len_reg     <= '0;
            partial_reg <= '0;
            pos_reg     <= '0;
            found_reg   <= '0;
        end
        else
        begin
            if (tolerance_wr_en)
            begin
                tol_reg <= tolerance_wr_data;
            end
            if (cmd.fire)
            begin
                len_reg     <= len_next;
                partial_reg <= partial_next;
                pos_reg     <= pos_next;
                found_reg   <= found_next;
            end
        end
    end

    // No partial-match bit may sit at or above the current pattern length.
    a_partial_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (partial_reg >> len_reg) == '0)
        else $error("partial-match bit set beyond pattern length");

    // A full match needs a non-empty pattern and an in-range pool position.
    a_match_needs_pattern: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fire && match) |-> (len_reg != '0 && pool_ok))
        else $error("match reported without a usable pattern");

    // The match count moves only when a beat is processed.
    a_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.fire |=> (found_reg == $past(found_reg)))
        else $error("match count changed without a beat");

endmodule

@@ dv/tolerant_sequence_match_test.sv @@
// Self-checking testbench for tolerant_sequence_match: a cycle-free predictor of the search
// state checks every result beat. Depends on tsm_pkg and the tolerant_sequence_match RTL.
`timescale 1ns / 1ps

module tolerant_sequence_match_test;
    import tsm_pkg::*;

    localparam int MAX_PATTERN    = 32;
    localparam int VALUE_BITS     = 12;
    localparam int INDEX_BITS     = 16;
    localparam int VALUE_MAX      = (1 << VALUE_BITS) - 1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF       = 300;
    localparam int PHASE_ITEMS    = 250;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [INDEX_BITS-1:0] POSITION_LIMIT = {INDEX_BITS{1'b1}};

    typedef struct packed {
        logic                  hit;
        logic [INDEX_BITS-1:0] start;
        logic [INDEX_BITS-1:0] total;
        logic                  ovf;
    } search_result_t;

    logic                  clk;
    logic                  rst_n             = 1'b0;
    logic                  tolerance_wr_en   = 1'b0;
    logic [TOL_BITS-1:0]   tolerance_wr_data = '0;
    logic                  in_valid          = 1'b0;
    logic                  in_stall;
    logic [1:0]            mode              = MODE_APPEND;
    logic [VALUE_BITS-1:0] value             = '0;
    logic                  out_valid;
    logic                  out_stall         = 1'b0;
    logic                  match;
    logic [INDEX_BITS-1:0] start_index;
    logic [INDEX_BITS-1:0] match_total;
    logic                  overflow;

    // Predicted state of the search.
    logic [TOL_BITS-1:0]   tol_reg = '0;
    logic [VALUE_BITS-1:0] pat_store [MAX_PATTERN];
    int                    pat_len = 0;
    logic [MAX_PATTERN-1:0] partial = '0;
    logic [INDEX_BITS-1:0] pool_pos = '0;
    logic [INDEX_BITS-1:0] found = '0;

    search_result_t awaited_results [$];
    int items_sent     = 0;
    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;

    tolerant_sequence_match #(
        .MAX_PATTERN (MAX_PATTERN),
        .VALUE_BITS  (VALUE_BITS),
        .INDEX_BITS  (INDEX_BITS)
    ) dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .tolerance_wr_en   (tolerance_wr_en),
        .tolerance_wr_data (tolerance_wr_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .mode              (mode),
        .value             (value),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .match             (match),
        .start_index       (start_index),
        .match_total       (match_total),
        .overflow          (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic search_result_t search_step(input logic [1:0] m,
                                                   input logic [VALUE_BITS-1:0] v);
        search_result_t         r;
        logic [MAX_PATTERN-1:0] hits;
        int                     i;
        int                     d;
        r = '0;
        case (m)
            MODE_APPEND:
            begin
                if (pat_len >= MAX_PATTERN)
                    r.ovf = 1'b1;
                else
                begin
                    pat_store[pat_len] = v;
                    pat_len++;
                end
            end
            MODE_POOL:
            begin
                if (pool_pos == POSITION_LIMIT)
                    r.ovf = 1'b1;
                else
                begin
                    hits = '0;
                    for (i = 0; i < pat_len; i++)
                    begin
                        d = int'(v) - int'(pat_store[i]);
                        if (d < 0)
                            d = -d;
                        if (d <= int'(tol_reg))
                            hits[i] = 1'b1;
                    end
                    partial = ((partial << 1) | 1) & hits;
                    if (pat_len > 0 && partial[pat_len-1])
                    begin
                        r.hit   = 1'b1;
                        r.start = pool_pos - INDEX_BITS'(pat_len - 1);
                        if (found != POSITION_LIMIT)
                            found++;
                    end
                    pool_pos++;
                end
            end
            MODE_RESTART:
            begin
                pat_len  = 0;
                partial  = '0;
                pool_pos = '0;
                found    = '0;
            end
            default: ;
        endcase
        r.total = found;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // One input beat, preceded by random idle cycles in which the payload is noise.
    task automatic send_item(input logic [1:0] m, input logic [VALUE_BITS-1:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            mode     <= 2'($urandom);
            value    <= VALUE_BITS'($urandom);
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
        awaited_results = {awaited_results, search_step(m, v)};
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_tolerance(input logic [TOL_BITS-1:0] t);
        wait_drained();
        tolerance_wr_en   <= 1'b1;
        tolerance_wr_data <= t;
        @(posedge clk);
        tolerance_wr_en <= 1'b0;
        tol_reg = t;
    endtask

    // A pool value near a pattern element, occasionally one step outside the tolerance.
    function automatic logic [VALUE_BITS-1:0] jittered(input logic [VALUE_BITS-1:0] e);
        int spread;
        int r;
        spread = int'(tol_reg) + (($urandom_range(4) == 0) ? 1 : 0);
        r = int'(e) + int'($urandom_range(0, 2 * spread)) - spread;
        if (r < 0)
            r = 0;
        if (r > VALUE_MAX)
            r = VALUE_MAX;
        return VALUE_BITS'(r);
    endfunction

    // Restart (in most bursts), load a pattern, then stream occurrences of it mixed with noise.
    task automatic run_search_burst();
        int                    len;
        int                    runs;
        int                    k;
        int                    j;
        bit                    narrow;
        logic [VALUE_BITS-1:0] base;
        narrow = ($urandom_range(9) < 3);
        base   = VALUE_BITS'($urandom_range(0, VALUE_MAX - 3));
        if ($urandom_range(9) != 0)
            send_item(MODE_RESTART, VALUE_BITS'($urandom));
        len = ($urandom_range(9) == 0) ? $urandom_range(6, MAX_PATTERN + 2)
                                       : $urandom_range(1, 5);
        for (k = 0; k < len; k++)
            send_item(MODE_APPEND, narrow ? base + VALUE_BITS'($urandom_range(3))
                                          : VALUE_BITS'($urandom));
        runs = $urandom_range(4, 12);
        for (k = 0; k < runs; k++)
        begin
            case ($urandom_range(19))
                0: send_item(MODE_UNUSED, VALUE_BITS'($urandom));
                1: send_item(MODE_APPEND, VALUE_BITS'($urandom));
                2, 3, 4:
                begin
                    for (j = $urandom_range(1, 6); j > 0; j--)
                        send_item(MODE_POOL, narrow ? base + VALUE_BITS'($urandom_range(3))
                                                    : VALUE_BITS'($urandom));
                end
                default:
                begin
                    for (j = 0; j < pat_len; j++)
                        send_item(MODE_POOL, jittered(pat_store[j]));
                end
            endcase
        end
    endtask

    task automatic test_directed();
        send_item(MODE_POOL, 12'd7);        // empty pattern never matches
        send_item(MODE_UNUSED, 12'hFFF);
        send_item(MODE_APPEND, 12'd0);
        send_item(MODE_APPEND, 12'hFFF);
        send_item(MODE_POOL, 12'd0);
        send_item(MODE_POOL, 12'hFFF);
        send_item(MODE_POOL, 12'd1);
        send_item(MODE_RESTART, 12'hFFF);
        write_tolerance(8'hFF);
        send_item(MODE_APPEND, 12'd0);
        send_item(MODE_POOL, 12'd255);
        send_item(MODE_POOL, 12'd256);
        // The new element only joins from the next pool value on.
        send_item(MODE_APPEND, 12'hFFF);
        send_item(MODE_POOL, 12'd3840);
        send_item(MODE_POOL, 12'd200);
        send_item(MODE_POOL, 12'd3840);
        send_item(MODE_POOL, 12'd3839);
        send_item(MODE_UNUSED, 12'd0);
        send_item(MODE_RESTART, 12'd0);
    endtask

    task automatic test_pattern_full();
        int i;
        write_tolerance(8'd0);
        send_item(MODE_RESTART, 12'd0);
        for (i = 0; i < MAX_PATTERN; i++)
            send_item(MODE_APPEND, VALUE_BITS'(i * 127));
        send_item(MODE_APPEND, 12'hFFF);
        send_item(MODE_APPEND, 12'd0);
        for (i = 0; i < 2 * MAX_PATTERN; i++)
            send_item(MODE_POOL, pat_store[i % MAX_PATTERN]);
        send_item(MODE_POOL, 12'd1);
    endtask

    task automatic test_random_search();
        int phase;
        int first;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    write_tolerance(8'd0);
                end
                1:
                begin
                    send_idle_pct = 67;
                    stall_pct     = 0;
                    write_tolerance(8'hFF);
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 67;
                    write_tolerance(TOL_BITS'($urandom_range(1, 254)));
                end
                default:
                begin
                    send_idle_pct = 36;
                    stall_pct     = 36;
                    write_tolerance(TOL_BITS'($urandom_range(1, 8)));
                end
            endcase
            first = items_sent;
            while (items_sent - first < PHASE_ITEMS)
                run_search_burst();
        end
    endtask

    task automatic test_backpressure();
        int first;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = HOLD_OFF;
        first = items_sent;
        while (items_sent - first < 40)
            run_search_burst();
        wait_drained();
        send_idle_pct = 36;
        stall_pct     = 36;
        run_search_burst();
    endtask

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        search_result_t want;
        if (out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
                report_mismatch("result beat with nothing awaited");
            else
            begin
                want = awaited_results.pop_front();
                if (match !== want.hit)
                    report_mismatch($sformatf("match %0b, predicted %0b", match, want.hit));
                if (start_index !== want.start)
                    report_mismatch($sformatf("start_index %0d, predicted %0d",
                                              start_index, want.start));
                if (match_total !== want.total)
                    report_mismatch($sformatf("match_total %0d, predicted %0d",
                                              match_total, want.total));
                if (overflow !== want.ovf)
                    report_mismatch($sformatf("overflow %0b, predicted %0b",
                                              overflow, want.ovf));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
        begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_pattern_full();
        test_random_search();
        test_backpressure();
        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
